/* rtl/sop_pkg.sv */
package sop_pkg;

    localparam int RAND_W   = 31;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNUSED    = 2'd3;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_NEXT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MODE = 1'd1;

    typedef struct packed {
        logic              req_type;
        logic [RAND_W-1:0] rand_value;
    } t_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  entry_index;
        logic                list_empty;
    } t_result;

endpackage

/* rtl/sop_ram.sv */
module sop_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sop_mod.sv */
// Restoring remainder unit: one dividend bit per cycle, MSB first.
module sop_mod
    import sop_pkg::*;
#(
    parameter int DIV_W = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RAND_W-1:0] i_dividend,
    input  logic [DIV_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [DIV_W-1:0]  o_remainder
);

    localparam int STEP_W = $clog2(RAND_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_steps;
    logic [RAND_W-1:0] r_dvd;
    logic [DIV_W-1:0]  r_dsr;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W:0]    trial;
    logic [DIV_W-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[RAND_W-1]};
        if (trial >= {1'b0, r_dsr}) begin
            n_rem = DIV_W'(trial - {1'b0, r_dsr});
        end else begin
            n_rem = trial[DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_steps <= STEP_W'(RAND_W);
                r_dvd   <= i_dividend;
                r_dsr   <= i_divisor;
                r_rem   <= '0;
            end else if (r_busy) begin
                r_rem   <= n_rem;
                r_dvd   <= {r_dvd[RAND_W-2:0], 1'b0};
                r_steps <= r_steps - 1'b1;
                if (r_steps == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

endmodule

/* rtl/shuffle_or_sequential_picker_core.sv */
// Channel   Direction  Handshake                     Beat
// -------   ---------  ----------------------------  ------------------------------
// request   in         start & !busy                 i_item (req_type, rand_value)
// result    out        o_result_valid, one cycle     o_result (status, index, empty)
// config    in         i_cfg_valid & o_cfg_ready     i_cfg_index, i_cfg_data
//
// One request is in flight at a time; busy drops in the cycle of its result beat.
// Add, table full, no entries and exhausted next go straight to the result beat;
// sequential next first makes one registered slot read; random next runs 31
// remainder steps (rand mod pool), then two slot reads and two write-backs,
// then the result beat.
// Reset (synchronous, active low) clears counts, modes and control; slot RAM
// contents are not cleared, only entries below the entry count are ever read.
// Config is ready only while idle with start low. The receiver cannot stall.
module shuffle_or_sequential_picker_core
    import sop_pkg::*;
#(
    parameter int MAX_ENTRIES = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_item                i_item,
    output logic                 o_result_valid,
    output t_result              o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic                 i_cfg_data
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_RDA,
        S_RDB,
        S_WRA,
        S_WRB,
        S_SEQ,
        S_SEQD,
        S_RESP
    } t_state;

    t_state r_state;

    // Architectural state
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_seq;
    logic [CNT_W-1:0] r_pool;
    logic             r_random;
    logic             r_repeat;

    // Per-request working registers
    logic [IDX_W-1:0]    r_addr;
    logic [IDX_W-1:0]    r_pick;
    logic [IDX_W-1:0]    r_last;
    logic [IDX_W-1:0]    r_t;
    logic [IDX_W-1:0]    r_idx;
    logic [STATUS_W-1:0] r_status;

    logic    r_out_valid;
    t_result r_out;

    // Slot RAM port
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_rdata;

    // Remainder unit
    logic             mod_start;
    logic             mod_done;
    logic [CNT_W-1:0] mod_rem;

    logic accept;
    logic full;
    logic empty_now;

    assign accept = start && (r_state == S_IDLE);
    assign full   = (r_count == CNT_W'(MAX_ENTRIES));

    always_comb begin
        if (r_count == '0) begin
            empty_now = 1'b1;
        end else if (r_repeat) begin
            empty_now = 1'b0;
        end else if (r_random) begin
            empty_now = (r_pool == '0);
        end else begin
            empty_now = (r_seq == r_count);
        end
    end

    // Write port: append on add, swap write-back on random next
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pick;
        ram_wdata = ram_rdata;
        unique case (r_state)
            S_IDLE: begin
                ram_we    = accept && (i_item.req_type == REQ_ADD) && !full;
                ram_waddr = r_count[IDX_W-1:0];
                ram_wdata = r_count[IDX_W-1:0];
            end
            S_WRA: begin
                ram_we    = 1'b1;
                ram_waddr = r_pick;
                ram_wdata = ram_rdata;
            end
            S_WRB: begin
                ram_we    = 1'b1;
                ram_waddr = r_last;
                ram_wdata = r_t;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign mod_start = accept && (i_item.req_type == REQ_NEXT) && r_random
                       && (r_count != '0) && ((r_pool != '0) || r_repeat);

    sop_ram #(
        .WIDTH(IDX_W),
        .DEPTH(MAX_ENTRIES)
    ) u_slots (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_addr),
        .o_rdata(ram_rdata)
    );

    sop_mod #(
        .DIV_W(CNT_W)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (i_item.rand_value),
        .i_divisor  ((r_pool == '0) ? r_count : r_pool),
        .o_done     (mod_done),
        .o_remainder(mod_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_seq       <= '0;
            r_pool      <= '0;
            r_random    <= 1'b0;
            r_repeat    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;

            // Take a configuration beat only while idle
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_RANDOM_MODE: r_random <= i_cfg_data;
                    CFG_REPEAT_MODE: r_repeat <= i_cfg_data;
                    default:         r_repeat <= r_repeat;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_RESP;
                        r_idx   <= '0;
                        if (i_item.req_type == REQ_ADD) begin
                            if (full) begin
                                r_status <= ST_FULL;
                                r_pool   <= r_count;
                            end else begin
                                r_status <= ST_OK;
                                r_idx    <= r_count[IDX_W-1:0];
                                r_count  <= r_count + 1'b1;
                                r_pool   <= r_count + 1'b1;
                            end
                        end else if (r_count == '0) begin
                            r_status <= ST_EXHAUSTED;
                        end else if (r_random) begin
                            if ((r_pool == '0) && !r_repeat) begin
                                r_status <= ST_EXHAUSTED;
                            end else begin
                                // Refill an empty pool before the pick
                                if (r_pool == '0) begin
                                    r_pool <= r_count;
                                end
                                r_status <= ST_OK;
                                r_state  <= S_DIV;
                            end
                        end else begin
                            if ((r_seq >= r_count) && !r_repeat) begin
                                r_status <= ST_EXHAUSTED;
                            end else begin
                                r_status <= ST_OK;
                                r_state  <= S_SEQ;
                                if (r_seq >= r_count) begin
                                    r_addr <= '0;
                                    r_seq  <= CNT_W'(1);
                                end else begin
                                    r_addr <= r_seq[IDX_W-1:0];
                                    r_seq  <= r_seq + 1'b1;
                                end
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (mod_done) begin
                        r_pick  <= mod_rem[IDX_W-1:0];
                        r_addr  <= mod_rem[IDX_W-1:0];
                        r_last  <= IDX_W'(r_pool - 1'b1);
                        r_state <= S_RDA;
                    end
                end
                S_RDA: begin
                    // Pick slot is being read; queue the tail slot read
                    r_addr  <= r_last;
                    r_state <= S_RDB;
                end
                S_RDB: begin
                    r_t     <= ram_rdata;
                    r_state <= S_WRA;
                end
                S_WRA: begin
                    r_state <= S_WRB;
                end
                S_WRB: begin
                    r_idx   <= r_t;
                    r_pool  <= r_pool - 1'b1;
                    r_state <= S_RESP;
                end
                S_SEQ: begin
                    r_state <= S_SEQD;
                end
                S_SEQD: begin
                    r_idx   <= ram_rdata;
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    // Result beat: list_empty is judged on the state left by this request
                    r_out_valid       <= 1'b1;
                    r_out.status      <= r_status;
                    r_out.entry_index <= INDEX_W'(r_idx);
                    r_out.list_empty  <= empty_now;
                    r_state           <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;
    assign o_cfg_ready    = (r_state == S_IDLE) && !start;

`ifndef SYNTHESIS
    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pool <= r_count)
        else $error("pool size exceeds entry count");

    a_seq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq <= r_count)
        else $error("sequential position beyond entry count");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_result.status != ST_UNUSED))
        else $error("unused status code on result");

    a_mod_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> (r_state == S_DIV))
        else $error("remainder done outside divide state");
`endif

endmodule

/* verif/shuffle_or_sequential_picker_core_test.sv */
module shuffle_or_sequential_picker_core_test
    import sop_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH  = 256;
    localparam int RANDOM_ITEMS = 560;
    localparam int END_CYCLES   = 40;

    // Mirror of the picker: slot table, counters, modes and the queue of
    // results still owed by the block, oldest first.
    class pick_scoreboard;
        logic [INDEX_W-1:0] slots [TABLE_DEPTH];
        int unsigned        entry_count;
        int unsigned        seq_pos;
        int unsigned        pool_left;
        logic               random_mode;
        logic               repeat_mode;
        t_result            owed_results [$];
        int                 errors;

        function new();
            entry_count = 0;
            seq_pos     = 0;
            pool_left   = 0;
            random_mode = 1'b0;
            repeat_mode = 1'b0;
            errors      = 0;
        endfunction

        function void set_mode(logic [CFG_IDX_W-1:0] idx, logic val);
            if (idx == CFG_RANDOM_MODE)
                random_mode = val;
            else if (idx == CFG_REPEAT_MODE)
                repeat_mode = val;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function logic nothing_left();
            if (entry_count == 0)
                return 1'b1;
            if (repeat_mode)
                return 1'b0;
            if (random_mode)
                return pool_left == 0;
            return seq_pos == entry_count;
        endfunction

        function t_result pick_outcome(t_item req);
            t_result            r;
            int unsigned        pick;
            int unsigned        last;
            logic [INDEX_W-1:0] held;
            r.status      = ST_OK;
            r.entry_index = '0;
            if (req.req_type == REQ_ADD) begin
                if (entry_count >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    slots[entry_count] = entry_count[INDEX_W-1:0];
                    r.entry_index      = entry_count[INDEX_W-1:0];
                    entry_count++;
                end
                pool_left = entry_count;
            end else if (entry_count == 0) begin
                r.status = ST_EXHAUSTED;
            end else if (random_mode) begin
                if (pool_left == 0 && !repeat_mode) begin
                    r.status = ST_EXHAUSTED;
                end else begin
                    if (pool_left == 0)
                        pool_left = entry_count;
                    if (pool_left > entry_count)
                        pool_left = entry_count;
                    pick = {1'b0, req.rand_value} % pool_left;
                    last = pool_left - 1;
                    held = slots[pick];
                    slots[pick] = slots[last];
                    slots[last] = held;
                    r.entry_index = held;
                    pool_left--;
                end
            end else begin
                if (seq_pos >= entry_count && !repeat_mode) begin
                    r.status = ST_EXHAUSTED;
                end else begin
                    if (seq_pos >= entry_count)
                        seq_pos = 0;
                    r.entry_index = slots[seq_pos];
                    seq_pos++;
                end
            end
            r.list_empty = nothing_left();
            return r;
        endfunction

        function void note_request(t_item req);
            owed_results.push_back(pick_outcome(req));
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (owed_results.size() == 0) begin
                $error("result beat with nothing owed: status %0d index %0d empty %0d",
                       got.status, got.entry_index, got.list_empty);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.entry_index !== want.entry_index) begin
                $error("entry_index: expected %0d, actual %0d",
                       want.entry_index, got.entry_index);
                errors++;
            end
            if (got.list_empty !== want.list_empty) begin
                $error("list_empty: expected %0d, actual %0d",
                       want.list_empty, got.list_empty);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    t_item                i_item = '0;
    logic                 o_result_valid;
    t_result              o_result;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic                 i_cfg_data = 1'b0;

    pick_scoreboard sb;

    shuffle_or_sequential_picker_core #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 12 ns clock: low half, then high half.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Catch every result beat: it is on the ports for a single cycle and
    // cannot be held off, so sample it at the edge that closes that cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            sb.check_result(o_result);
    end

    // Hard stop in case the block hangs or stops answering.
    initial begin
        #5_000_000;
        $display("[shuffle_or_sequential_picker_core] ERROR");
        $finish;
    end

    function automatic t_item make_request(logic req, logic [RAND_W-1:0] rnd);
        t_item it;
        it.req_type   = req;
        it.rand_value = rnd;
        return it;
    endfunction

    // Draw one request: add with the given percentage, else next. Mostly
    // full-width random values, with the extremes mixed in.
    function automatic t_item random_request(int add_pct);
        logic [RAND_W-1:0] rnd;
        int                pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            rnd = '0;
        else if (pick == 1)
            rnd = '1;
        else
            rnd = RAND_W'($urandom());
        if ($urandom_range(0, 99) < add_pct)
            return make_request(REQ_ADD, rnd);
        return make_request(REQ_NEXT, rnd);
    endfunction

    // Present one request beat and hold it until the block takes it.
    // Called at a rising edge; returns at the edge that accepted the beat,
    // with start still high so a back-to-back beat needs no glitch.
    task automatic send_item(t_item req);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= req;
        do @(posedge i_clk); while (busy);
        sb.note_request(req);
    endtask

    // Drop start and wait until every owed result has come back.
    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0 || busy) @(posedge i_clk);
    endtask

    // Write one mode register with the block idle, then step past the edge of
    // the handshake so the next beat never shares its time step.
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_mode(idx, val);
        @(posedge i_clk);
    endtask

    initial begin
        int sent;
        int phase;
        int len;
        int add_pct;
        int n;

        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Next with no entries, in both modes.
        send_item(make_request(REQ_NEXT, '0));
        write_cfg(CFG_RANDOM_MODE, 1'b1);
        send_item(make_request(REQ_NEXT, '1));

        // Three entries, then drain the random pool past its end without
        // repeat: the last next must report exhausted.
        repeat (3) send_item(make_request(REQ_ADD, '0));
        send_item(make_request(REQ_NEXT, '1));
        send_item(make_request(REQ_NEXT, '0));
        send_item(make_request(REQ_NEXT, RAND_W'($urandom())));
        send_item(make_request(REQ_NEXT, RAND_W'($urandom())));

        // Sequential order now walks the shuffled table, then runs out.
        write_cfg(CFG_RANDOM_MODE, 1'b0);
        repeat (4) send_item(make_request(REQ_NEXT, RAND_W'($urandom())));

        // Repeat: sequential order wraps, random pool refills.
        write_cfg(CFG_REPEAT_MODE, 1'b1);
        repeat (2) send_item(make_request(REQ_NEXT, '0));
        write_cfg(CFG_RANDOM_MODE, 1'b1);
        repeat (4) send_item(make_request(REQ_NEXT, RAND_W'($urandom())));

        // An add in the middle of a shuffle resets the pool to all entries.
        send_item(make_request(REQ_ADD, '1));
        send_item(make_request(REQ_NEXT, '1));

        // Random phases: fresh modes per phase, add density varied so the
        // pool and the sequential order both get used up now and then.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            write_cfg(CFG_RANDOM_MODE, logic'($urandom_range(0, 1)));
            write_cfg(CFG_REPEAT_MODE, logic'($urandom_range(0, 1)));
            case ($urandom_range(0, 3))
                0: add_pct = 3;
                1: add_pct = 12;
                2: add_pct = 30;
                default: add_pct = 60;
            endcase
            len = $urandom_range(20, 60);
            for (n = 0; n < len; n++) begin
                // Hold off mid-phase until the block has answered everything.
                if (n == len / 2 && (phase == 0 || $urandom_range(0, 3) == 0))
                    drain();
                send_item(random_request(add_pct));
                sent++;
            end
            phase++;
        end

        // Fill the table to the top, then push adds against a full table.
        write_cfg(CFG_RANDOM_MODE, 1'b1);
        write_cfg(CFG_REPEAT_MODE, 1'b0);
        while (sb.entry_count < TABLE_DEPTH)
            send_item(make_request(REQ_ADD, RAND_W'($urandom())));
        repeat (3) send_item(make_request(REQ_ADD, RAND_W'($urandom())));
        repeat (30) send_item(random_request(0));
        write_cfg(CFG_RANDOM_MODE, 1'b0);
        repeat (30) send_item(random_request(5));

        // Let the last results come in, then keep the clock running so that anything
        // stray is still caught.
        drain();
        repeat (END_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[shuffle_or_sequential_picker_core] OK");
        end else begin
            if (sb.pending() != 0)
                $error("%0d results never arrived", sb.pending());
            $display("[shuffle_or_sequential_picker_core] ERROR");
        end
        $finish;
    end

endmodule

/* shuffle_or_sequential_picker_core.f */
rtl/sop_pkg.sv
rtl/sop_ram.sv
rtl/sop_mod.sv
rtl/shuffle_or_sequential_picker_core.sv
verif/shuffle_or_sequential_picker_core_test.sv
